>>> design/hgbp_pkg.sv
// ----------------------------------------------------------------------------
// hgbp_pkg: shared types and constants for the hybrid branch predictor
// Counter encodings, reset values and the controller state type.
// ----------------------------------------------------------------------------
package hgbp_pkg;

    // 2-bit saturating counter values
    localparam logic [1:0] CNT_MIN        = 2'd0;
    localparam logic [1:0] CNT_WEAK_NOT   = 2'd1;
    localparam logic [1:0] CNT_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CNT_MAX        = 2'd3;

    // history_length register reset value
    localparam logic [3:0] HIST_LEN_RESET = 4'd8;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // counter predicts taken at weak-taken or above
    function automatic logic cnt_taken(input logic [1:0] c);
        return c[1];
    endfunction

    // saturate one step toward the given direction
    function automatic logic [1:0] sat_toward(input logic [1:0] c, input logic up);
        logic [1:0] r;
        if (up) begin
            r = (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
        end else begin
            r = (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

>>> design/hybrid_gshare_bimodal_predictor.sv
// ----------------------------------------------------------------------------
// hybrid_gshare_bimodal_predictor: gshare + bimodal with per-PC chooser
// Takes resolved branches, reports the hybrid prediction made before the
// update, then trains the chosen counter, the chooser and global history.
// ----------------------------------------------------------------------------
//  channel   ports                                   direction  word
//  s_        s_valid/s_ready, s_branch_pc, s_taken   in         one branch
//  m_        m_valid/m_ready, m_prediction,          out        one result
//            m_used_gshare, m_gshare_guess,
//            m_bimodal_guess, m_mispredicted
//  cfg_      cfg_wr_en, cfg_wr_data                  in         history_length
//
//  A branch goes through the synchronous table read, then a step that
//  modifies and writes back the counters and loads the output register.
//  After reset a clearing pass, stepped by a counter max(index bits) wide
//  (10 bits by default), writes every table entry; s_ready stays low meanwhile.
//  A result waiting on m_ready holds the update cycle until the output
//  register frees; cfg writes are taken at any time.
// ----------------------------------------------------------------------------
module hybrid_gshare_bimodal_predictor
    import hgbp_pkg::*;
#(
    parameter int GSHARE_INDEX_BITS  = 10,
    parameter int BIMODAL_INDEX_BITS = 5,
    parameter int CHOOSER_INDEX_BITS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // branch input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_branch_pc,
    input  logic        s_taken,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_prediction,
    output logic        m_used_gshare,
    output logic        m_gshare_guess,
    output logic        m_bimodal_guess,
    output logic        m_mispredicted
);

    localparam int G = GSHARE_INDEX_BITS;
    localparam int B = BIMODAL_INDEX_BITS;
    localparam int C = CHOOSER_INDEX_BITS;
    localparam int HW = $clog2(G + 1);
    localparam int BC_MAX = (B > C) ? B : C;
    localparam int CLR_BITS = (G > BC_MAX) ? G : BC_MAX;

    // tables
    logic [1:0] gsh_mem [2**G];
    logic [1:0] bim_mem [2**B];
    logic [1:0] cho_mem [2**C];

    state_t state_reg, state_next;
    logic [CLR_BITS-1:0] clr_cnt_reg;
    logic [3:0]   hist_len_reg;
    logic [G-1:0] hist_reg, hist_next;

    // captured branch
    logic [G-1:0] gi_reg;
    logic [B-1:0] bi_reg;
    logic [C-1:0] ci_reg;
    logic         taken_reg;

    // registered read data
    logic [1:0] gsh_rd_reg, bim_rd_reg, cho_rd_reg;

    // output register
    logic m_valid_reg, m_valid_next;
    logic pred_reg, use_g_reg, g_guess_reg, b_guess_reg, mis_reg;

    logic         accept;
    logic         out_load;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] hist_shift;
    logic [G-1:0] gi_in;
    logic [B-1:0] bi_in;
    logic [C-1:0] ci_in;
    logic         g_guess, b_guess, use_g, pred;

    logic         gsh_we, bim_we, cho_we;
    logic [G-1:0] gsh_waddr;
    logic [B-1:0] bim_waddr;
    logic [C-1:0] cho_waddr;
    logic [1:0]   gsh_wdata, bim_wdata, cho_wdata;

    // effective history length, clamped to 1..G
    always_comb begin
        if (hist_len_reg == 4'd0) begin
            h_eff = HW'(1);
        end else if (32'(hist_len_reg) > G) begin
            h_eff = HW'(G);
        end else begin
            h_eff = HW'(hist_len_reg);
        end
        hist_shift = HW'(G) - h_eff;
    end

    // table indices from the incoming word
    assign gi_in = s_branch_pc[G+1:2] ^ (hist_reg << hist_shift);
    assign bi_in = s_branch_pc[B+1:2];
    assign ci_in = s_branch_pc[C+1:2];

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);

    // guesses from the read data
    assign g_guess = cnt_taken(gsh_rd_reg);
    assign b_guess = cnt_taken(bim_rd_reg);
    assign use_g   = cnt_taken(cho_rd_reg);
    assign pred    = use_g ? g_guess : b_guess;

    // controller
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // write-back: clearing pass or counter update
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            gsh_we    = 1'b1;
            bim_we    = 1'b1;
            cho_we    = 1'b1;
            gsh_waddr = clr_cnt_reg[G-1:0];
            bim_waddr = clr_cnt_reg[B-1:0];
            cho_waddr = clr_cnt_reg[C-1:0];
            gsh_wdata = CNT_WEAK_TAKEN;
            bim_wdata = CNT_WEAK_TAKEN;
            cho_wdata = CNT_WEAK_NOT;
        end else begin
            gsh_we    = out_load && use_g;
            bim_we    = out_load && !use_g;
            cho_we    = out_load && (g_guess != b_guess);
            gsh_waddr = gi_reg;
            bim_waddr = bi_reg;
            cho_waddr = ci_reg;
            gsh_wdata = sat_toward(gsh_rd_reg, taken_reg);
            bim_wdata = sat_toward(bim_rd_reg, taken_reg);
            cho_wdata = sat_toward(cho_rd_reg, g_guess == taken_reg);
        end
    end

    // history: shift right, outcome flips bit h-1
    always_comb begin
        hist_next = hist_reg;
        if (out_load) begin
            hist_next = (hist_reg >> 1) ^ (G'(taken_reg) << (h_eff - HW'(1)));
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            hist_len_reg <= HIST_LEN_RESET;
            hist_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hist_reg    <= hist_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_BITS'(1);
            end
            if (cfg_wr_en) begin
                hist_len_reg <= cfg_wr_data;
            end
        end
    end

    // captured branch and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            gi_reg    <= gi_in;
            bi_reg    <= bi_in;
            ci_reg    <= ci_in;
            taken_reg <= s_taken;
        end
        if (out_load) begin
            pred_reg    <= pred;
            use_g_reg   <= use_g;
            g_guess_reg <= g_guess;
            b_guess_reg <= b_guess;
            mis_reg     <= pred != taken_reg;
        end
    end

    // gshare table
    always_ff @(posedge aclk) begin
        if (gsh_we) begin
            gsh_mem[gsh_waddr] <= gsh_wdata;
        end
        if (accept) begin
            gsh_rd_reg <= gsh_mem[gi_in];
        end
    end

    // bimodal table
    always_ff @(posedge aclk) begin
        if (bim_we) begin
            bim_mem[bim_waddr] <= bim_wdata;
        end
        if (accept) begin
            bim_rd_reg <= bim_mem[bi_in];
        end
    end

    // chooser table
    always_ff @(posedge aclk) begin
        if (cho_we) begin
            cho_mem[cho_waddr] <= cho_wdata;
        end
        if (accept) begin
            cho_rd_reg <= cho_mem[ci_in];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_prediction    = pred_reg;
    assign m_used_gshare   = use_g_reg;
    assign m_gshare_guess  = g_guess_reg;
    assign m_bimodal_guess = b_guess_reg;
    assign m_mispredicted  = mis_reg;

    // an accepted word always moves on to the update cycle
    a_accept_update: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_UPDATE))
        else $error("accepted word did not reach update");

    // the reported prediction is the chosen component's guess
    a_pred_select: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prediction == (m_used_gshare ? m_gshare_guess : m_bimodal_guess)))
        else $error("prediction does not match chosen component");

    // history changes only on a completed update
    a_hist_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(hist_reg))
        else $error("history changed without an update");

    // no input is taken until the clearing pass is done
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("word accepted during clearing pass");

    // at most one component counter written per branch
    a_one_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |-> !(gsh_we && bim_we))
        else $error("both component counters written");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for hybrid_gshare_bimodal_predictor
// Drives resolved branches through the valid/ready input, keeps a private
// model of the bimodal, gshare and chooser tables plus global history, and
// checks every result word field by field in order. A short directed list
// comes first, then pattern-driven random traffic under several history
// lengths and three idling mixes on the two channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hgbp_pkg::*;

    localparam int GSH_BITS = 10;
    localparam int BIM_BITS = 5;
    localparam int CHO_BITS = 5;
    localparam int GSH_SIZE = 1 << GSH_BITS;
    localparam int BIM_SIZE = 1 << BIM_BITS;
    localparam int CHO_SIZE = 1 << CHO_BITS;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 203;
    localparam int POOL_SIZE       = 8;

    // behavior of one recurring branch in the random traffic
    typedef enum logic [1:0] {
        KIND_LOOP,
        KIND_FIXED,
        KIND_CORREL
    } branch_kind_t;

    // one result word, msb first: prediction .. mispredicted
    typedef struct packed {
        logic prediction;
        logic used_gshare;
        logic gshare_guess;
        logic bimodal_guess;
        logic mispredicted;
    } branch_report_t;

    typedef struct {
        logic [31:0]    pc;
        logic           taken;
        logic           fixed;
        branch_report_t want;
    } stim_row_t;

    // DUT signals
    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic [3:0]  cfg_wr_data     = '0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [31:0] s_branch_pc     = '0;
    logic        s_taken         = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_prediction;
    logic        m_used_gshare;
    logic        m_gshare_guess;
    logic        m_bimodal_guess;
    logic        m_mispredicted;

    // side data that travels with each input word
    logic           row_fixed = 1'b0;
    branch_report_t row_want  = '0;

    // model state
    logic [1:0]     gsh_ctr [GSH_SIZE];
    logic [1:0]     bim_ctr [BIM_SIZE];
    logic [1:0]     cho_ctr [CHO_SIZE];
    logic [9:0]     model_ghist;
    logic [3:0]     model_hist_len;

    branch_report_t pred_reports [$];
    stim_row_t      stim_rows [$];
    int             fail_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    hybrid_gshare_bimodal_predictor #(
        .GSHARE_INDEX_BITS  (GSH_BITS),
        .BIMODAL_INDEX_BITS (BIM_BITS),
        .CHOOSER_INDEX_BITS (CHO_BITS)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_branch_pc     (s_branch_pc),
        .s_taken         (s_taken),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prediction    (m_prediction),
        .m_used_gshare   (m_used_gshare),
        .m_gshare_guess  (m_gshare_guess),
        .m_bimodal_guess (m_bimodal_guess),
        .m_mispredicted  (m_mispredicted)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #1000000;
        $display("hybrid_gshare_bimodal_predictor test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic logic [1:0] nudge_counter(input logic [1:0] c, input logic up);
        if (up) begin
            return (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
        end
        return (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < GSH_SIZE; i++) gsh_ctr[i] = CNT_WEAK_TAKEN;
        for (int i = 0; i < BIM_SIZE; i++) bim_ctr[i] = CNT_WEAK_TAKEN;
        for (int i = 0; i < CHO_SIZE; i++) cho_ctr[i] = CNT_WEAK_NOT;
        model_ghist    = '0;
        model_hist_len = HIST_LEN_RESET;
    endfunction

    // predict from the current tables, then train them on the outcome
    function automatic branch_report_t hybrid_predict(input logic [31:0] pc,
                                                      input logic tk);
        branch_report_t r;
        logic [29:0]    word;
        int unsigned    h;
        logic [9:0]     gidx;
        logic [4:0]     bidx;
        logic [4:0]     cidx;

        word = pc[31:2];
        h = 32'(model_hist_len);
        if (h < 1) h = 1;
        if (h > GSH_BITS) h = GSH_BITS;

        gidx = word[9:0] ^ (model_ghist << (GSH_BITS - h));
        bidx = word[4:0];
        cidx = word[4:0];

        r.gshare_guess  = (gsh_ctr[gidx] >= CNT_WEAK_TAKEN);
        r.bimodal_guess = (bim_ctr[bidx] >= CNT_WEAK_TAKEN);
        r.used_gshare   = (cho_ctr[cidx] >= CNT_WEAK_TAKEN);
        r.prediction    = r.used_gshare ? r.gshare_guess : r.bimodal_guess;
        r.mispredicted  = (r.prediction != tk);

        if (r.used_gshare) begin
            gsh_ctr[gidx] = nudge_counter(gsh_ctr[gidx], tk);
        end else begin
            bim_ctr[bidx] = nudge_counter(bim_ctr[bidx], tk);
        end

        // outcome enters at bit h-1; stale upper bits just shift down
        model_ghist = (model_ghist >> 1) ^ ({9'b0, tk} << (h - 1));

        if (r.gshare_guess != r.bimodal_guess) begin
            cho_ctr[cidx] = nudge_counter(cho_ctr[cidx], r.gshare_guess == tk);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    // results first, so a word out with nothing pending is caught
    always @(posedge aclk) begin
        branch_report_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pred_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with nothing pending, expected none, actual %05b",
                             $time, {m_prediction, m_used_gshare, m_gshare_guess,
                                     m_bimodal_guess, m_mispredicted});
                end else begin
                    want = pred_reports.pop_front();
                    check_field("prediction",    want.prediction,    m_prediction);
                    check_field("used_gshare",   want.used_gshare,   m_used_gshare);
                    check_field("gshare_guess",  want.gshare_guess,  m_gshare_guess);
                    check_field("bimodal_guess", want.bimodal_guess, m_bimodal_guess);
                    check_field("mispredicted",  want.mispredicted,  m_mispredicted);
                end
            end
            if (s_valid && s_ready) begin
                want = hybrid_predict(s_branch_pc, s_taken);
                pred_reports.push_back(row_fixed ? row_want : want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side backpressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_row(input logic [31:0] pc, input logic tk, input logic fixed,
                           input branch_report_t want);
        stim_row_t row;
        row.pc    = pc;
        row.taken = tk;
        row.fixed = fixed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // present one branch word and wait for its handshake
    task automatic send_branch(input logic [31:0] pc, input logic tk, input logic fixed,
                               input branch_report_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_branch_pc <= pc;
        s_taken     <= tk;
        row_fixed   <= fixed;
        row_want    <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and wait out every pending result
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pred_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_hist_len(input logic [3:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        model_hist_len = v;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [3:0]   phase_hist [PHASES];
        logic [31:0]  pool_pc [POOL_SIZE];
        branch_kind_t pool_kind [POOL_SIZE];
        int           pool_period [POOL_SIZE];
        int           pool_count [POOL_SIZE];
        logic         pool_dir [POOL_SIZE];
        logic [31:0]  pc;
        logic         tk;
        logic         last_taken;
        int           k;

        clear_tables();
        last_taken = 1'b0;

        phase_hist[0] = 4'd1;
        phase_hist[1] = 4'd10;
        phase_hist[2] = 4'd0;
        phase_hist[3] = 4'd15;
        phase_hist[4] = HIST_LEN_RESET;
        phase_hist[5] = 4'd3;
        phase_hist[6] = 4'd10;
        phase_hist[7] = 4'd1;
        phase_hist[8] = 4'($urandom_range(0, 15));

        // directed rows; fresh tables make the first three obvious
        add_row(32'h0000_0000, 1'b0, 1'b1, 5'b10111);
        add_row(32'hFFFF_FFFF, 1'b1, 1'b1, 5'b10110);
        add_row(32'h0000_0000, 1'b0, 1'b1, 5'b00100);
        // low two pc bits do not change the index
        add_row(32'h0000_0003, 1'b1, 1'b0, '0);
        add_row(32'h0000_0001, 1'b0, 1'b0, '0);
        // saturate a bimodal counter at the top, then the bottom
        add_row(32'hFFFF_FFFC, 1'b1, 1'b0, '0);
        add_row(32'hFFFF_FFFC, 1'b1, 1'b0, '0);
        add_row(32'hFFFF_FFFE, 1'b0, 1'b0, '0);
        add_row(32'hFFFF_FFFC, 1'b0, 1'b0, '0);
        add_row(32'hFFFF_FFFD, 1'b0, 1'b0, '0);
        add_row(32'hFFFF_FFFC, 1'b0, 1'b0, '0);
        // alternating bit patterns
        add_row(32'h5555_5555, 1'b1, 1'b0, '0);
        add_row(32'hAAAA_AAAA, 1'b0, 1'b0, '0);
        add_row(32'h5555_5554, 1'b0, 1'b0, '0);
        add_row(32'hAAAA_AAA8, 1'b1, 1'b0, '0);
        // train bimodal down, then pull the chooser over to gshare
        for (int i = 0; i < 3; i++) add_row(32'h0000_0004, 1'b0, 1'b0, '0);
        for (int i = 0; i < 5; i++) add_row(32'h0000_0004, 1'b1, 1'b0, '0);
        // aliasing of a high pc onto the same small-table entry
        add_row(32'h8000_0004, 1'b0, 1'b0, '0);
        add_row(32'h8000_0004, 1'b1, 1'b0, '0);

        send_idle_pct = 28;
        recv_idle_pct = 72;

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        foreach (stim_rows[i]) begin
            send_branch(stim_rows[i].pc, stim_rows[i].taken, stim_rows[i].fixed,
                        stim_rows[i].want);
            last_taken = stim_rows[i].taken;
        end
        settle();

        // random phases: three idling mixes, three history lengths each
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_hist_len(phase_hist[phase]);

            // a few recurring branches with learnable behavior
            for (int i = 0; i < POOL_SIZE; i++) begin
                pool_pc[i]     = $urandom;
                pool_kind[i]   = branch_kind_t'($urandom_range(0, 2));
                pool_period[i] = $urandom_range(2, 7);
                pool_count[i]  = 0;
                pool_dir[i]    = 1'($urandom_range(0, 1));
            end
            // force an alias on the small tables now and then
            if ($urandom_range(0, 1)) begin
                pool_pc[1][6:2] = pool_pc[0][6:2];
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 80) begin
                    k  = $urandom_range(0, POOL_SIZE - 1);
                    pc = pool_pc[k];
                    case (pool_kind[k])
                        KIND_LOOP: begin
                            tk = (pool_count[k] != pool_period[k] - 1);
                            pool_count[k] = (pool_count[k] + 1) % pool_period[k];
                        end
                        KIND_FIXED: begin
                            tk = pool_dir[k];
                        end
                        default: begin
                            tk = last_taken ^ pool_dir[k];
                        end
                    endcase
                end else begin
                    // noise: any pc, any outcome
                    pc = $urandom;
                    tk = 1'($urandom_range(0, 1));
                end
                last_taken = tk;
                send_branch(pc, tk, 1'b0, '0);
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        if (pred_reports.size() != 0) begin
            fail_count++;
            $display("%0t: results missing, expected 0 pending, actual %0d",
                     $time, pred_reports.size());
        end

        if (fail_count == 0) begin
            $display("hybrid_gshare_bimodal_predictor test passed");
        end else begin
            $display("hybrid_gshare_bimodal_predictor test failed");
        end
        $finish;
    end

endmodule
